// ----- rtl/gma_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gma_pkg
// Shared types and constants for the Gaussian misfit accumulator.
// ----------------------------------------------------------------------------
package gma_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_SCALE_G0 = 2'd0,
        CFG_SCALE_G1 = 2'd1,
        CFG_LOG_G0   = 2'd2,
        CFG_LOG_G1   = 2'd3
    } cfg_index_t;

    localparam int CFG_DATA_W = 32;
    localparam int SCALE_W    = 31;
    localparam int VALUE_W    = 32;
    localparam int TOTAL_W    = 48;

    localparam int PROD_W = 64;            // shared 32x32 multiplier output
    localparam int P_W    = 62;            // sigma * scale, Q30.32
    localparam int VAR_W  = 124;           // P^2
    localparam int SUB_W  = VAR_W + 1;     // trial remainder width

    localparam int WEIGHT_BITS = 32;       // quotient bits kept for the weight
    localparam int MISFIT_BITS = 48;       // quotient bits kept for the misfit term
    localparam int CNT_W       = 6;

    localparam logic [31:0] SCALE_RESET   = 32'd65536;
    localparam logic [33:0] NORM_CONST_Q  = 34'd60224;  // 0.5*ln(2*pi), Q16.16
    localparam logic [47:0] MISFIT_MAX    = 48'hFFFF_FFFF_FFFF;
    localparam logic [47:0] NORM_MAX      = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] NORM_MIN      = 48'h8000_0000_0000;
    localparam logic [31:0] WEIGHT_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] WEIGHT_MIN    = 32'h8000_0000;

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b0000_0000_0001,
        ST_MUL_P  = 12'b0000_0000_0010,
        ST_LOAD_P = 12'b0000_0000_0100,
        ST_MUL_00 = 12'b0000_0000_1000,
        ST_MUL_01 = 12'b0000_0001_0000,
        ST_MUL_11 = 12'b0000_0010_0000,
        ST_MUL_RR = 12'b0000_0100_0000,
        ST_W_INIT = 12'b0000_1000_0000,
        ST_W_DIV  = 12'b0001_0000_0000,
        ST_M_INIT = 12'b0010_0000_0000,
        ST_M_DIV  = 12'b0100_0000_0000,
        ST_FINISH = 12'b1000_0000_0000
    } state_t;

endpackage

// ----- rtl/gaussian_misfit_accumulator_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_misfit_accumulator_unit
// Gaussian negative log likelihood accumulator over a set of observations.
// ----------------------------------------------------------------------------
// Each accepted beat is one observation. The block forms the residual, the
// scaled sigma P = noise_sigma * scale(group), its square with a shared
// 32x32 multiplier (five products), then runs one shared 125-bit
// restoring divider: a range check plus 32 steps for the weight and a
// range check plus 48 steps for the misfit term; the steps are skipped
// when the range check finds that the quotient saturates. in_ready is low
// while an item is being worked on; a finished result waits in the output
// register while the next item is accepted. The item flagged last_item
// returns both totals and clears them.
// ----------------------------------------------------------------------------
module gaussian_misfit_accumulator_unit #(
    parameter int NUM_GROUPS = 2
) (
    input  logic                clk,
    input  logic                rst_n,

    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,

    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [31:0]  predicted,
    input  logic signed [31:0]  observed,
    input  logic [30:0]         noise_sigma,
    input  logic signed [31:0]  log_noise_sigma,
    input  logic                group,
    input  logic                last_item,

    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  residual,
    output logic signed [31:0]  misfit_weight,
    output logic [47:0]         misfit_total,
    output logic signed [47:0]  norm_total,
    output logic                set_done
);

    localparam int GW   = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int G_HI = NUM_GROUPS - 1;

    gma_pkg::state_t state_reg, state_next;

    // configuration
    logic [gma_pkg::SCALE_W-1:0]  scale_reg     [NUM_GROUPS];
    logic signed [31:0]           log_scale_reg [NUM_GROUPS];

    // item registers
    logic signed [32:0]           res_reg;
    logic [31:0]                  mag_reg;
    logic [30:0]                  sigma_reg;
    logic signed [31:0]           lsig_reg;
    logic [GW-1:0]                g_reg;
    logic                         last_reg;

    // datapath
    logic [gma_pkg::PROD_W-1:0]   prod_reg;
    logic [gma_pkg::P_W-1:0]      p_reg;
    logic [gma_pkg::VAR_W-1:0]    var_reg;
    logic [gma_pkg::VAR_W-1:0]    rem_reg;
    logic [gma_pkg::MISFIT_BITS-1:0] q_reg;
    logic [gma_pkg::CNT_W-1:0]    cnt_reg;
    logic                         sat_w_reg;
    logic                         sat_m_reg;
    logic [31:0]                  weight_reg;

    // accumulators
    logic [47:0]                  misfit_acc_reg;
    logic signed [47:0]           norm_acc_reg;

    // output register
    logic                         out_valid_reg;
    logic signed [31:0]           residual_reg;
    logic signed [31:0]           weight_out_reg;
    logic [47:0]                  misfit_total_reg;
    logic signed [47:0]           norm_total_reg;
    logic                         set_done_reg;

    logic                         in_fire;
    logic                         out_free;

    logic signed [32:0]           res_in;
    logic [31:0]                  mul_a;
    logic [31:0]                  mul_b;
    logic [gma_pkg::PROD_W-1:0]   prod_next;

    logic                         div_bit;
    logic [gma_pkg::SUB_W-1:0]    sub_a;
    logic [gma_pkg::SUB_W:0]      diff;
    logic                         div_ge;

    logic [31:0]                  weight_next;
    logic [47:0]                  term_m;
    logic [48:0]                  misfit_sum;
    logic [47:0]                  misfit_acc_next;
    logic signed [33:0]           term_n;
    logic signed [48:0]           norm_sum;
    logic signed [47:0]           norm_acc_next;
    logic signed [31:0]           residual_sat;

    assign in_ready = (state_reg == gma_pkg::ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign res_in = 33'(predicted) - 33'(observed);

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            gma_pkg::ST_MUL_P:
            begin
                mul_a = {1'b0, sigma_reg};
                mul_b = {1'b0, scale_reg[g_reg]};
            end
            gma_pkg::ST_MUL_00:
            begin
                mul_a = p_reg[31:0];
                mul_b = p_reg[31:0];
            end
            gma_pkg::ST_MUL_01:
            begin
                mul_a = p_reg[31:0];
                mul_b = {2'b00, p_reg[61:32]};
            end
            gma_pkg::ST_MUL_11:
            begin
                mul_a = {2'b00, p_reg[61:32]};
                mul_b = {2'b00, p_reg[61:32]};
            end
            gma_pkg::ST_MUL_RR:
            begin
                mul_a = mag_reg;
                mul_b = mag_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    // shared trial subtractor; the init states use it for the range check
    assign div_bit = (state_reg == gma_pkg::ST_M_DIV) &&
                     (cnt_reg == gma_pkg::CNT_W'(gma_pkg::MISFIT_BITS)) && prod_reg[0];

    always_comb
    begin
        case (state_reg)
            gma_pkg::ST_W_INIT: sub_a = {61'b0, mag_reg, 32'b0};
            gma_pkg::ST_M_INIT: sub_a = {62'b0, prod_reg[63:1]};
            default:            sub_a = {rem_reg, div_bit};
        endcase
    end

    assign diff   = {1'b0, sub_a} - {2'b00, var_reg};
    assign div_ge = !diff[gma_pkg::SUB_W];

    // weight from the 32-bit quotient
    always_comb
    begin
        if (sat_w_reg)
            weight_next = res_reg[32] ? gma_pkg::WEIGHT_MIN : gma_pkg::WEIGHT_MAX;
        else if (res_reg[32])
            weight_next = (q_reg[31:0] > gma_pkg::WEIGHT_MIN) ? gma_pkg::WEIGHT_MIN
                                                               : (32'd0 - q_reg[31:0]);
        else
            weight_next = (q_reg[31:0] > gma_pkg::WEIGHT_MAX) ? gma_pkg::WEIGHT_MAX
                                                               : q_reg[31:0];
    end

    // accumulator updates
    assign term_m     = sat_m_reg ? gma_pkg::MISFIT_MAX : q_reg;
    assign misfit_sum = {1'b0, misfit_acc_reg} + {1'b0, term_m};
    assign misfit_acc_next = misfit_sum[48] ? gma_pkg::MISFIT_MAX : misfit_sum[47:0];

    assign term_n   = $signed(gma_pkg::NORM_CONST_Q) + 34'(lsig_reg) + 34'(log_scale_reg[g_reg]);
    assign norm_sum = 49'(norm_acc_reg) + 49'(term_n);

    always_comb
    begin
        if (norm_sum[48] != norm_sum[47])
            norm_acc_next = norm_sum[48] ? gma_pkg::NORM_MIN : gma_pkg::NORM_MAX;
        else
            norm_acc_next = norm_sum[47:0];
    end

    always_comb
    begin
        if (res_reg[32] != res_reg[31])
            residual_sat = res_reg[32] ? gma_pkg::WEIGHT_MIN : gma_pkg::WEIGHT_MAX;
        else
            residual_sat = res_reg[31:0];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gma_pkg::ST_IDLE:   if (in_fire) state_next = gma_pkg::ST_MUL_P;
            gma_pkg::ST_MUL_P:  state_next = gma_pkg::ST_LOAD_P;
            gma_pkg::ST_LOAD_P: state_next = gma_pkg::ST_MUL_00;
            gma_pkg::ST_MUL_00: state_next = gma_pkg::ST_MUL_01;
            gma_pkg::ST_MUL_01: state_next = gma_pkg::ST_MUL_11;
            gma_pkg::ST_MUL_11: state_next = gma_pkg::ST_MUL_RR;
            gma_pkg::ST_MUL_RR: state_next = gma_pkg::ST_W_INIT;
            gma_pkg::ST_W_INIT: state_next = div_ge ? gma_pkg::ST_M_INIT : gma_pkg::ST_W_DIV;
            gma_pkg::ST_W_DIV:
                if (cnt_reg == gma_pkg::CNT_W'(1)) state_next = gma_pkg::ST_M_INIT;
            gma_pkg::ST_M_INIT: state_next = div_ge ? gma_pkg::ST_FINISH : gma_pkg::ST_M_DIV;
            gma_pkg::ST_M_DIV:
                if (cnt_reg == gma_pkg::CNT_W'(1)) state_next = gma_pkg::ST_FINISH;
            gma_pkg::ST_FINISH: if (out_free) state_next = gma_pkg::ST_IDLE;
            default:            state_next = gma_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gma_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                scale_reg[g]     <= gma_pkg::SCALE_RESET[gma_pkg::SCALE_W-1:0];
                log_scale_reg[g] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gma_pkg::CFG_SCALE_G0: scale_reg[0] <= cfg_data[gma_pkg::SCALE_W-1:0];
                gma_pkg::CFG_SCALE_G1:
                    if (NUM_GROUPS > 1) scale_reg[G_HI] <= cfg_data[gma_pkg::SCALE_W-1:0];
                gma_pkg::CFG_LOG_G0:   log_scale_reg[0] <= cfg_data;
                gma_pkg::CFG_LOG_G1:
                    if (NUM_GROUPS > 1) log_scale_reg[G_HI] <= cfg_data;
                default: ;
            endcase
        end
    end

    // item capture and datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_reg   <= res_in;
            mag_reg   <= res_in[32] ? 32'(33'd0 - res_in) : res_in[31:0];
            sigma_reg <= noise_sigma;
            lsig_reg  <= log_noise_sigma;
            g_reg     <= (int'(group) >= NUM_GROUPS) ? GW'(G_HI) : GW'(group);
            last_reg  <= last_item;
        end

        case (state_reg)
            gma_pkg::ST_MUL_P:  prod_reg <= prod_next;
            gma_pkg::ST_LOAD_P:
                p_reg <= (prod_reg[61:0] == '0) ? gma_pkg::P_W'(1) : prod_reg[61:0];
            gma_pkg::ST_MUL_00: prod_reg <= prod_next;
            gma_pkg::ST_MUL_01:
            begin
                var_reg  <= {60'b0, prod_reg};
                prod_reg <= prod_next;
            end
            gma_pkg::ST_MUL_11:
            begin
                var_reg  <= var_reg + {27'b0, prod_reg, 33'b0};
                prod_reg <= prod_next;
            end
            gma_pkg::ST_MUL_RR:
            begin
                var_reg  <= var_reg + {prod_reg[59:0], 64'b0};
                prod_reg <= prod_next;
            end
            gma_pkg::ST_W_INIT:
            begin
                sat_w_reg <= div_ge;
                rem_reg   <= sub_a[gma_pkg::VAR_W-1:0];
                cnt_reg   <= gma_pkg::CNT_W'(gma_pkg::WEIGHT_BITS);
            end
            gma_pkg::ST_M_INIT:
            begin
                weight_reg <= weight_next;
                sat_m_reg  <= div_ge;
                rem_reg    <= sub_a[gma_pkg::VAR_W-1:0];
                cnt_reg    <= gma_pkg::CNT_W'(gma_pkg::MISFIT_BITS);
            end
            gma_pkg::ST_W_DIV, gma_pkg::ST_M_DIV:
            begin
                rem_reg <= div_ge ? diff[gma_pkg::VAR_W-1:0] : sub_a[gma_pkg::VAR_W-1:0];
                q_reg   <= {q_reg[gma_pkg::MISFIT_BITS-2:0], div_ge};
                cnt_reg <= cnt_reg - gma_pkg::CNT_W'(1);
            end
            default: ;
        endcase
    end

    // accumulators and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            misfit_acc_reg <= '0;
            norm_acc_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if ((state_reg == gma_pkg::ST_FINISH) && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    misfit_acc_reg <= '0;
                    norm_acc_reg   <= '0;
                end
                else
                begin
                    misfit_acc_reg <= misfit_acc_next;
                    norm_acc_reg   <= norm_acc_next;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == gma_pkg::ST_FINISH) && out_free)
        begin
            residual_reg     <= residual_sat;
            weight_out_reg   <= weight_reg;
            misfit_total_reg <= last_reg ? misfit_acc_next : '0;
            norm_total_reg   <= last_reg ? norm_acc_next : '0;
            set_done_reg     <= last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign residual      = residual_reg;
    assign misfit_weight = weight_out_reg;
    assign misfit_total  = misfit_total_reg;
    assign norm_total    = norm_total_reg;
    assign set_done      = set_done_reg;

endmodule

// ----- rtl/gma_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gma_checker
// Port-level checks for the Gaussian misfit accumulator.
// ----------------------------------------------------------------------------
module gma_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         in_valid,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [31:0]  residual,
    input logic [31:0]  misfit_weight,
    input logic [47:0]  misfit_total,
    input logic [47:0]  norm_total,
    input logic         set_done
);

    // one item at a time: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("in_ready high right after an accepted beat");

    // the result never shows up in the cycle after acceptance
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after acceptance");

    // totals are only reported at the end of a set
    a_totals_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !set_done |-> misfit_total == 48'd0 && norm_total == 48'd0)
        else $error("nonzero totals on a non-final beat");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(residual) &&
                                    $stable(misfit_weight) && $stable(set_done))
        else $error("stalled result changed");

endmodule

bind gaussian_misfit_accumulator_unit gma_checker u_gma_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .residual      (residual),
    .misfit_weight (misfit_weight),
    .misfit_total  (misfit_total),
    .norm_total    (norm_total),
    .set_done      (set_done)
);
